// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the vertex transform.
// Depends on nothing; files that assert include it inside their module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside of reset.
`define VTP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition at one rising edge requires a property from the next edge on.
`define VTP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/vtp_pkg.sv =====
// Shared types and constants of the vertex transform with perspective divide.
// No dependencies.
package vtp_pkg;

   // Width of every coordinate field on the ports.
   localparam int unsigned DATA_WIDTH = 32;
   // Width of one matrix register.
   localparam int unsigned CSR_DATA_WIDTH = 64;
   localparam int unsigned CSR_ADDR_WIDTH = 3;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_COL0_XY = 3'd0,
      CSR_COL0_ZW = 3'd1,
      CSR_COL1_XY = 3'd2,
      CSR_COL1_ZW = 3'd3,
      CSR_COL2_XY = 3'd4,
      CSR_COL2_ZW = 3'd5,
      CSR_COL3_XY = 3'd6,
      CSR_COL3_ZW = 3'd7
   } csr_index_type;

endpackage

// ===== rtl/vertex_transform_perspective.sv =====
// Vertex transform by a column-major 4x4 matrix followed by the perspective
// divide of x, y and z by the transformed w. A new word may enter while
// earlier ones are still in flight; the quotient is formed one bit per
// pipeline stage after three stages of multiply and sum and one preparation
// stage, and the result is registered at the output. When the result side stalls,
// the whole pipeline holds. After reset the matrix is the identity.
module vertex_transform_perspective #(
   parameter int unsigned COORD_WIDTH = 32,
   parameter int unsigned FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input words; tdata from bit 0: in_x, in_y, in_z, in_w (32 bits each).
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [4*vtp_pkg::DATA_WIDTH-1:0]    req_tdata,
   // Result words; tdata from bit 0: out_x, out_y, out_z (32 bits each).
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [3*vtp_pkg::DATA_WIDTH-1:0]    rsp_tdata,
   // tuser from bit 0: divide_by_zero, saturated.
   output logic [1:0]                          rsp_tuser,
   // Matrix register writes.
   input  logic                                csr_we,
   input  logic [vtp_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [vtp_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import vtp_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned PW = 2 * CW;       // one product
   localparam int unsigned HW = PW + 1;       // sum of two products
   localparam int unsigned SW = PW + 2;       // row sum, also magnitude width
   localparam int unsigned NW = SW + FRAC_BITS;
   localparam int unsigned HALF = CSR_DATA_WIDTH / 2;
   localparam logic [CSR_DATA_WIDTH-1:0] ONE_LO = CSR_DATA_WIDTH'(1) << FRAC_BITS;
   localparam logic [CSR_DATA_WIDTH-1:0] ONE_HI = ONE_LO << HALF;
   localparam logic [CW:0] LIM = (CW+1)'(1) << (CW - 1);

   // Matrix registers.
   logic [CSR_DATA_WIDTH-1:0] mat_ff [0:7];

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff[CSR_COL0_XY] <= ONE_LO;
         mat_ff[CSR_COL0_ZW] <= '0;
         mat_ff[CSR_COL1_XY] <= ONE_HI;
         mat_ff[CSR_COL1_ZW] <= '0;
         mat_ff[CSR_COL2_XY] <= '0;
         mat_ff[CSR_COL2_ZW] <= ONE_LO;
         mat_ff[CSR_COL3_XY] <= '0;
         mat_ff[CSR_COL3_ZW] <= ONE_HI;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_COL0_XY: mat_ff[CSR_COL0_XY] <= csr_wdata;
            CSR_COL0_ZW: mat_ff[CSR_COL0_ZW] <= csr_wdata;
            CSR_COL1_XY: mat_ff[CSR_COL1_XY] <= csr_wdata;
            CSR_COL1_ZW: mat_ff[CSR_COL1_ZW] <= csr_wdata;
            CSR_COL2_XY: mat_ff[CSR_COL2_XY] <= csr_wdata;
            CSR_COL2_ZW: mat_ff[CSR_COL2_ZW] <= csr_wdata;
            CSR_COL3_XY: mat_ff[CSR_COL3_XY] <= csr_wdata;
            CSR_COL3_ZW: mat_ff[CSR_COL3_ZW] <= csr_wdata;
            default:     mat_ff[CSR_COL0_XY] <= mat_ff[CSR_COL0_XY];
         endcase
      end
   end

   // Matrix entries by column and row, taken from the low bits of each half.
   logic signed [CW-1:0] ent [0:3][0:3];
   logic signed [CW-1:0] vin [0:3];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         ent[c][0] = signed'(mat_ff[2*c][CW-1:0]);
         ent[c][1] = signed'(mat_ff[2*c][HALF+CW-1:HALF]);
         ent[c][2] = signed'(mat_ff[2*c+1][CW-1:0]);
         ent[c][3] = signed'(mat_ff[2*c+1][HALF+CW-1:HALF]);
         vin[c]    = signed'(req_tdata[c*DATA_WIDTH +: CW]);
      end
   end

   // The whole pipeline advances unless the output word is held.
   logic en;
   logic rsp_tvalid_ff;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Stage 1: sixteen products.
   logic                 v1_ff;
   logic signed [PW-1:0] prod_ff [0:3][0:3];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               prod_ff[r][c] <= ent[c][r] * vin[c];
      end
   end

   // Stage 2: pairs of products.
   logic                 v2_ff;
   logic signed [HW-1:0] pair_ff [0:3][0:1];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++) begin
            pair_ff[r][0] <= HW'(prod_ff[r][0]) + HW'(prod_ff[r][1]);
            pair_ff[r][1] <= HW'(prod_ff[r][2]) + HW'(prod_ff[r][3]);
         end
      end
   end

   // Stage 3: exact row sums.
   logic                 v3_ff;
   logic signed [SW-1:0] sum_ff [0:3];

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 4; r++)
            sum_ff[r] <= SW'(pair_ff[r][0]) + SW'(pair_ff[r][1]);
      end
   end

   // Divider pipeline: index 0 is the preparation stage, then one stage per
   // quotient bit from the most significant down.
   logic          dv_ff   [0:CW];
   logic          dz_ff   [0:CW];
   logic [SW-1:0] den_ff  [0:CW];
   logic [SW-1:0] rem_ff  [0:CW][0:2];
   logic [CW-1:0] nlow_ff [0:CW][0:2];
   logic [CW-1:0] quo_ff  [0:CW][0:2];
   logic          neg_ff  [0:CW][0:2];
   logic          ovf_ff  [0:CW][0:2];

   // Preparation: magnitudes, fraction shift and the high-quotient check.
   logic [SW-1:0] den_abs;
   logic [NW-1:0] num_sh  [0:2];
   logic [NW-1:0] num_top [0:2];

   always_comb begin
      den_abs = sum_ff[3][SW-1] ? SW'(-sum_ff[3]) : SW'(sum_ff[3]);
      for (int i = 0; i < 3; i++) begin
         num_sh[i]  = NW'(sum_ff[i][SW-1] ? SW'(-sum_ff[i]) : SW'(sum_ff[i])) << FRAC_BITS;
         num_top[i] = num_sh[i] >> CW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (en) dv_ff[0] <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dz_ff[0]  <= (sum_ff[3] == '0);
         den_ff[0] <= den_abs;
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i]  <= num_top[i][SW-1:0];
            nlow_ff[0][i] <= num_sh[i][CW-1:0];
            quo_ff[0][i]  <= '0;
            neg_ff[0][i]  <= sum_ff[i][SW-1] != sum_ff[3][SW-1];
            ovf_ff[0][i]  <= num_top[i] >= NW'(den_abs);
         end
      end
   end

   // One restoring step per stage.
   for (genvar k = 0; k < CW; k++) begin : g_div
      logic [SW:0] trial [0:2];
      logic        fits  [0:2];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            trial[i] = {rem_ff[k][i], nlow_ff[k][i][CW-1]};
            fits[i]  = trial[i] >= {1'b0, den_ff[k]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else if (en) dv_ff[k+1] <= dv_ff[k];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dz_ff[k+1]  <= dz_ff[k];
            den_ff[k+1] <= den_ff[k];
            for (int i = 0; i < 3; i++) begin
               rem_ff[k+1][i]  <= fits[i] ? SW'(trial[i] - {1'b0, den_ff[k]})
                                          : trial[i][SW-1:0];
               nlow_ff[k+1][i] <= nlow_ff[k][i] << 1;
               quo_ff[k+1][i]  <= {quo_ff[k][i][CW-2:0], fits[i]};
               neg_ff[k+1][i]  <= neg_ff[k][i];
               ovf_ff[k+1][i]  <= ovf_ff[k][i];
            end
         end
      end
   end

   // Final stage: sign, clamp and the output register.
   logic [CW-1:0]         res [0:2];
   logic [2:0]            sat_bit;
   logic [DATA_WIDTH-1:0] out_word [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (neg_ff[CW][i]) begin
            sat_bit[i] = ovf_ff[CW][i] || ({1'b0, quo_ff[CW][i]} > LIM);
            res[i]     = sat_bit[i] ? CW'(-LIM) : CW'(-{1'b0, quo_ff[CW][i]});
         end else begin
            sat_bit[i] = ovf_ff[CW][i] || ({1'b0, quo_ff[CW][i]} > (LIM - 1'b1));
            res[i]     = sat_bit[i] ? CW'(LIM - 1'b1) : quo_ff[CW][i];
         end
         out_word[i] = dz_ff[CW] ? '0 : DATA_WIDTH'(signed'(res[i]));
      end
   end

   logic [3*DATA_WIDTH-1:0] rsp_tdata_ff;
   logic [1:0]              rsp_tuser_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= dv_ff[CW];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff    <= {out_word[2], out_word[1], out_word[0]};
         rsp_tuser_ff[0] <= dz_ff[CW];
         rsp_tuser_ff[1] <= !dz_ff[CW] && (sat_bit != 3'b000);
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // A zero w sum yields zero coordinates and no saturation flag.
   `VTP_ASSERT(a_dz_zero, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1], "divide by zero result not cleared")
   // The pipeline only halts while a result waits at the output.
   `VTP_ASSERT_NEXT(a_stall_full, !req_tready, rsp_tvalid, "stall without a pending result")
   // The live preparation stage of the divider never holds a zero divisor unless flagged.
   `VTP_ASSERT(a_den_nonzero, dv_ff[0] && !dz_ff[0] |-> den_ff[0] != '0, "zero divisor in divider")

endmodule

// ===== tb/sv/vertex_transform_perspective_tb.sv =====
// Self-checking testbench of the vertex transform with perspective divide.
// Depends on vtp_pkg and vertex_transform_perspective; a scoreboard class
// predicts each result from its own copy of the matrix.
module vertex_transform_perspective_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vtp_pkg::*;

   localparam int FRAC = 16;
   localparam int PIPE_LATENCY = 37;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD = 300;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        dz;
      logic        sat;
   } projected_type;

   // Holds the matrix and the queue of projected vertices still to come out.
   class transform_scoreboard;
      logic [63:0]   matrix_reg[8];
      projected_type pending[$];
      int            errors;

      function new();
         errors = 0;
         matrix_reg[0] = 64'h0000_0000_0001_0000;
         matrix_reg[1] = 64'h0;
         matrix_reg[2] = 64'h0001_0000_0000_0000;
         matrix_reg[3] = 64'h0;
         matrix_reg[4] = 64'h0;
         matrix_reg[5] = 64'h0000_0000_0001_0000;
         matrix_reg[6] = 64'h0;
         matrix_reg[7] = 64'h0001_0000_0000_0000;
      endfunction

      function void write_reg(int idx, logic [63:0] value);
         matrix_reg[idx] = value;
      endfunction

      // Divides one row sum by the w sum, truncating toward zero, and clamps.
      function automatic logic [31:0] divide_row(logic signed [127:0] num,
                                                 logic signed [127:0] den,
                                                 ref logic sat);
         logic [127:0] n;
         logic [127:0] d;
         logic [127:0] q;
         logic         neg;
         neg = num[127] ^ den[127];
         n = num[127] ? -num : num;
         d = den[127] ? -den : den;
         n = n << FRAC;
         q = n / d;
         if (neg) begin
            if (q > 128'h8000_0000) begin
               sat = 1'b1;
               return 32'h8000_0000;
            end
            return -q[31:0];
         end
         if (q > 128'h7FFF_FFFF) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
         end
         return q[31:0];
      endfunction

      function automatic projected_type project(logic [127:0] vertex);
         logic signed [127:0] sums[4];
         logic signed [31:0]  coord[4];
         logic signed [31:0]  e;
         logic signed [63:0]  prod;
         logic [63:0]         r;
         logic                sat;
         projected_type       res;
         for (int c = 0; c < 4; c++) coord[c] = vertex[32*c +: 32];
         for (int row = 0; row < 4; row++) begin
            sums[row] = 0;
            for (int c = 0; c < 4; c++) begin
               r = matrix_reg[c*2 + row/2];
               e = (row % 2) ? r[63:32] : r[31:0];
               prod = e * coord[c];
               sums[row] = sums[row] + prod;
            end
         end
         sat = 1'b0;
         if (sums[3] == 0) begin
            res.x = 0;
            res.y = 0;
            res.z = 0;
            res.dz = 1'b1;
            res.sat = 1'b0;
         end else begin
            res.x = divide_row(sums[0], sums[3], sat);
            res.y = divide_row(sums[1], sums[3], sat);
            res.z = divide_row(sums[2], sums[3], sat);
            res.dz = 1'b0;
            res.sat = sat;
         end
         return res;
      endfunction

      function void note_vertex(logic [127:0] vertex);
         pending.push_back(project(vertex));
      endfunction

      function void check_result(logic [95:0] data, logic [1:0] user);
         projected_type exp_res;
         if (pending.size() == 0) begin
            $error("result word with no vertex pending");
            errors++;
            return;
         end
         exp_res = pending.pop_front();
         if (data[31:0] !== exp_res.x) begin
            $error("out_x expected %h actual %h", exp_res.x, data[31:0]);
            errors++;
         end
         if (data[63:32] !== exp_res.y) begin
            $error("out_y expected %h actual %h", exp_res.y, data[63:32]);
            errors++;
         end
         if (data[95:64] !== exp_res.z) begin
            $error("out_z expected %h actual %h", exp_res.z, data[95:64]);
            errors++;
         end
         if (user[0] !== exp_res.dz) begin
            $error("divide_by_zero expected %b actual %b", exp_res.dz, user[0]);
            errors++;
         end
         if (user[1] !== exp_res.sat) begin
            $error("saturated expected %b actual %b", exp_res.sat, user[1]);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   transform_scoreboard sb = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   bit hold_req = 0;
   int quiet_cycles = 0;

   vertex_transform_perspective DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: random stalls, plus a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Result check and watchdog on cycles with no word moving.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offers one vertex, with random idle cycles ahead of it.
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [31:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {w, z, y, x};
      do @(posedge clock); while (!req_tready);
      sb.note_vertex({w, z, y, x});
   endtask

   // Stops offering and waits for every pending result.
   task automatic wait_empty();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Writes all eight matrix registers while the pipeline is empty.
   task automatic load_matrix(logic [63:0] values[8]);
      wait_empty();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_addr <= csr_index_type'(i);
         csr_wdata <= values[i];
         @(posedge clock);
         sb.write_reg(i, values[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      logic [31:0] v;
      if (mode == 0) return $urandom;
      v = $urandom_range(32'h0008_0000);
      return $urandom_range(1) ? -v : v;
   endfunction

   function automatic logic [31:0] rand_entry(int kind);
      case (kind)
         0: return rand_coord(1) >>> 1;
         1: return $urandom;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return 32'h0;
      endcase
   endfunction

   initial begin
      logic [63:0] m[8];
      logic [31:0] w;
      int mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed vertices against the identity matrix.
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
      send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vertex(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 32'h0003_0000);
      send_vertex(32'hFFFF_FFFF, 32'h0005_0000, 32'h0, 32'hFFFD_0000);
      send_vertex(32'h8000_0000, 32'h0, 32'h0, 32'h0001_0000);
      send_vertex(32'h8000_0000, 32'h0, 32'h0, 32'hFFFF_0000);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vertex(32'h0, 32'h0, 32'h0, 32'h0);
      send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'h0000_8000);

      // Random phases, each with its own matrix; the idling pattern repeats every four phases.
      for (int k = 0; k < 7; k++) begin
         for (int i = 0; i < 8; i++)
            m[i] = {rand_entry(k % 5), rand_entry(k % 5)};
         if (k == 5) begin
            // Perspective projection: w row takes z, and y by the random column 1 entry.
            m[1] = {32'h0, 32'h0001_0000};
            m[5] = {32'h0001_0000, 32'h0001_0000};
            m[7] = {32'h0, 32'h0};
         end
         load_matrix(m);
         send_idle_pct = (k % 4 == 1 || k % 4 == 3) ? ((k % 4 == 1) ? 72 : 29) : 0;
         stall_pct = (k % 4 == 2 || k % 4 == 3) ? ((k % 4 == 2) ? 72 : 29) : 0;
         for (int n = 0; n < 75; n++) begin
            if (k == 1 && n == 20) begin
               send_idle_pct = 0;
               hold_req = 1;
            end
            if (k == 2 && n == 40) wait_empty();
            mode = $urandom_range(9);
            w = (mode == 0) ? 32'h0 : rand_coord(mode < 4 ? 0 : 1);
            send_vertex(rand_coord(mode < 4 ? 0 : 1), rand_coord(mode < 4 ? 0 : 1),
                        rand_coord(mode < 4 ? 0 : 1), w);
         end
      end

      wait_empty();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
